FILE: hw/rtl/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

  // fixed field widths
  localparam int MASK_INDEX_W = 10;
  localparam int ELEM_W       = 32;
  localparam int TOTAL_W      = 42;

  // defaults and sizes
  localparam int MASK_BITS_DEF = 10;
  localparam int QUEUE_DEPTH   = 2;

  // saturation bounds of the reported total
  localparam longint TOTAL_MAX = 64'sd2199023255551;
  localparam longint TOTAL_MIN = -64'sd2199023255552;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // one request as it sits in the queue
  typedef struct packed {
    op_e                             op;
    logic [MASK_INDEX_W-1:0]         mask_index;
    logic signed [ELEM_W-1:0]        element_value;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

FILE: hw/rtl/sst_front.sv
`timescale 1ns / 1ps

module sst_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [sst_pkg::MASK_INDEX_W-1:0] mask_index_i,
  input  logic signed [sst_pkg::ELEM_W-1:0] element_value_i,
  input  logic                            busy_i,
  output logic                            item_valid_o,
  input  logic                            item_ready_i,
  output sst_pkg::item_t                  item_o
);
  import sst_pkg::*;

  localparam int QPtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCntW = $clog2(QUEUE_DEPTH + 1);

  item_t             q_mem_q [QUEUE_DEPTH];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              push, pop;
  item_t             in_item;

  // classify the incoming request
  always_comb begin
    in_item.op            = op_e'(operation_i);
    in_item.mask_index    = mask_index_i;
    in_item.element_value = element_value_i;
  end

  // no requests while the table is being cleared or the queue is full
  assign in_ready_o   = (cnt_q != QCntW'(QUEUE_DEPTH)) && !busy_i;
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = q_mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

FILE: hw/rtl/sst_back.sv
`timescale 1ns / 1ps

module sst_back #(
  parameter int MASK_BITS = sst_pkg::MASK_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  output logic                             busy_o,
  input  logic                             item_valid_i,
  output logic                             item_ready_o,
  input  sst_pkg::item_t                   item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sst_pkg::MASK_INDEX_W-1:0] queried_mask_o,
  output logic signed [sst_pkg::TOTAL_W-1:0] submask_total_o
);
  import sst_pkg::*;

  localparam int Depth = 1 << MASK_BITS;
  localparam int AccW  = (MASK_BITS + ELEM_W + 1 > TOTAL_W) ? MASK_BITS + ELEM_W + 1 : TOTAL_W;
  localparam logic signed [AccW-1:0] TotMax = AccW'(TOTAL_MAX);
  localparam logic signed [AccW-1:0] TotMin = AccW'(TOTAL_MIN);

  logic signed [ELEM_W-1:0]  mem [Depth];

  state_e                    state_q, state_d;
  logic [MASK_BITS-1:0]      clr_q;
  logic [MASK_BITS-1:0]      mask_q;
  logic [MASK_BITS-1:0]      s_q;
  logic [MASK_BITS-1:0]      s_next;
  logic [MASK_BITS-1:0]      item_idx;
  logic                      rd_vld_q;
  logic signed [ELEM_W-1:0]  rdata_q;
  logic signed [AccW-1:0]    acc_q;
  logic signed [AccW-1:0]    acc_sat;
  logic                      out_vld_q;
  logic [MASK_INDEX_W-1:0]   out_mask_q;
  logic signed [TOTAL_W-1:0] out_total_q;

  logic                      mem_we;
  logic [MASK_BITS-1:0]      mem_waddr;
  logic signed [ELEM_W-1:0]  mem_wdata;
  logic                      take_query;
  logic                      out_load;

  assign item_idx = MASK_BITS'(item_i.mask_index);
  assign s_next   = mask_q & (s_q - MASK_BITS'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid_i && item_i.op == OP_QUERY) begin
          state_d = (item_idx == '0) ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (s_next == '0) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!out_vld_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy_o       = 1'b0;
    item_ready_o = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = item_idx;
    mem_wdata    = item_i.element_value;
    take_query   = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        busy_o    = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          mem_we     = (item_i.op == OP_LOAD);
          take_query = (item_i.op == OP_QUERY);
        end
      end
      ST_FINISH: begin
        out_load = !out_vld_q || out_ready_i;
      end
      default: ;
    endcase
  end

  // clamp the total to the reported range
  always_comb begin
    if (acc_q > TotMax) begin
      acc_sat = TotMax;
    end else if (acc_q < TotMin) begin
      acc_sat = TotMin;
    end else begin
      acc_sat = acc_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_WALK);
      if (state_q == ST_CLEAR) clr_q <= clr_q + MASK_BITS'(1);
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // submask walk and accumulation
  always_ff @(posedge clk_i) begin
    if (take_query) begin
      mask_q <= item_idx;
      s_q    <= item_idx;
      acc_q  <= '0;
    end else begin
      if (state_q == ST_WALK) s_q <= s_next;
      if (rd_vld_q) acc_q <= acc_q + AccW'(rdata_q);
    end
    if (out_load) begin
      out_mask_q  <= MASK_INDEX_W'(mask_q);
      out_total_q <= TOTAL_W'(acc_sat);
    end
  end

  // element table, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[s_q];
  end

  assign out_valid_o     = out_vld_q;
  assign queried_mask_o  = out_mask_q;
  assign submask_total_o = out_total_q;

endmodule

FILE: hw/rtl/submask_sum_table.sv
`timescale 1ns / 1ps

// channel  handshake                 payload
// in       in_valid_i / in_ready_o   operation_i, mask_index_i, element_value_i
// out      out_valid_o / out_ready_i queried_mask_o, submask_total_o
//
// the back end writes a load into the table as it takes it from the queue;
// a query walks the nonzero submasks of its mask, one table read per
// nonzero submask from the registered-read element memory (none for mask zero).
// after reset the table is cleared one entry a cycle, with in_ready_o
// low. a two-entry request queue lets the input keep flowing while a
// query walks or a result waits in the output register.

module submask_sum_table #(
  parameter int MASK_BITS = sst_pkg::MASK_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [sst_pkg::MASK_INDEX_W-1:0]   mask_index_i,
  input  logic signed [sst_pkg::ELEM_W-1:0]  element_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sst_pkg::MASK_INDEX_W-1:0]   queried_mask_o,
  output logic signed [sst_pkg::TOTAL_W-1:0] submask_total_o
);
  import sst_pkg::*;

  logic  busy;
  logic  item_valid;
  logic  item_ready;
  item_t item;

  // request intake and queue
  sst_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .mask_index_i    (mask_index_i),
    .element_value_i (element_value_i),
    .busy_i          (busy),
    .item_valid_o    (item_valid),
    .item_ready_i    (item_ready),
    .item_o          (item)
  );

  // table, submask walk and result register
  sst_back #(
    .MASK_BITS (MASK_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .busy_o          (busy),
    .item_valid_i    (item_valid),
    .item_ready_o    (item_ready),
    .item_i          (item),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .queried_mask_o  (queried_mask_o),
    .submask_total_o (submask_total_o)
  );

endmodule
